>>> hdl/fstc_pkg.sv
// Shared constants, knot tables and store control type for the force sensor
// filter, tare and conversion block.
// No dependencies.
package fstc_pkg;

    // Full-scale level in Q12.8 (4095 * 256) and conductance cap in Q20.8 uS
    localparam logic [19:0] LEVEL_FULL = 20'd1048320;
    localparam logic [27:0] COND_CAP   = 28'd256000000;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [14:0] FORCE_MAX  = 15'd20000;

    // Divider operand widths
    localparam int NUM_W = 48;
    localparam int DEN_W = 40;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_TFRAMES = 2'd1;
    localparam logic [1:0] REG_SAT     = 2'd2;
    localparam logic [1:0] REG_RLOAD   = 2'd3;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TARE   = 1'b1;

    // Read and write strobes toward the channel stores
    typedef struct packed {
        logic rd;
        logic wr_filt;
        logic wr_cond;
        logic wr_sum;
    } store_ctl_t;

    // Conductance knots in whole microsiemens
    function automatic logic [9:0] cond_knot(input logic [2:0] i);
        logic [9:0] v;
        case (i)
            3'd0:    v = 10'd0;
            3'd1:    v = 10'd9;
            3'd2:    v = 10'd19;
            3'd3:    v = 10'd32;
            3'd4:    v = 10'd54;
            3'd5:    v = 10'd141;
            3'd6:    v = 10'd284;
            3'd7:    v = 10'd554;
            default: v = 10'd0;
        endcase
        return v;
    endfunction

    // Force knots in millinewtons
    function automatic logic [14:0] force_knot(input logic [2:0] i);
        logic [14:0] v;
        case (i)
            3'd0:    v = 15'd0;
            3'd1:    v = 15'd200;
            3'd2:    v = 15'd500;
            3'd3:    v = 15'd1000;
            3'd4:    v = 15'd2000;
            3'd5:    v = 15'd5000;
            3'd6:    v = 15'd10000;
            3'd7:    v = 15'd20000;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/fstc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the conductance,
// force interpolation and tare averaging steps. Uses fstc_pkg.
module fstc_div
    import fstc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diffv;
    logic             take;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diffv = trial - {1'b0, den_reg};
        take  = trial >= {1'b0, den_reg};
    end

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift quotient bits in, keep the partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diffv[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> hdl/fstc_store.sv
// Per-channel stores: filtered level, tare conductance and tare sum, each a
// synchronous memory with registered read. Uses fstc_pkg.
module fstc_store
    import fstc_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int AW       = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  store_ctl_t    ctl,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [19:0]   filt_wdata,
    input  logic [27:0]   cond_wdata,
    input  logic [37:0]   sum_wdata,
    output logic [19:0]   filt_rdata,
    output logic [27:0]   cond_rdata,
    output logic [37:0]   sum_rdata
);

    logic [19:0] filt_mem [CHANNELS];
    logic [27:0] cond_mem [CHANNELS];
    logic [37:0] sum_mem  [CHANNELS];

    logic [CHANNELS-1:0] filt_vld_reg;
    logic [CHANNELS-1:0] cond_vld_reg;
    logic [CHANNELS-1:0] sum_vld_reg;

    logic [19:0] filt_q_reg;
    logic [27:0] cond_q_reg;
    logic [37:0] sum_q_reg;
    logic        filt_qv_reg;
    logic        cond_qv_reg;
    logic        sum_qv_reg;

    // Write the arrays
    always_ff @(posedge clk)
    begin
        if (ctl.wr_filt)
        begin
            filt_mem[wr_addr] <= filt_wdata;
        end
        if (ctl.wr_cond)
        begin
            cond_mem[wr_addr] <= cond_wdata;
        end
        if (ctl.wr_sum)
        begin
            sum_mem[wr_addr] <= sum_wdata;
        end
        if (ctl.rd)
        begin
            filt_q_reg <= filt_mem[rd_addr];
            cond_q_reg <= cond_mem[rd_addr];
            sum_q_reg  <= sum_mem[rd_addr];
        end
    end

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_vld_reg <= '0;
            cond_vld_reg <= '0;
            sum_vld_reg  <= '0;
            filt_qv_reg  <= 1'b0;
            cond_qv_reg  <= 1'b0;
            sum_qv_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.wr_filt)
            begin
                filt_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.wr_cond)
            begin
                cond_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.wr_sum)
            begin
                sum_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                filt_qv_reg <= filt_vld_reg[rd_addr];
                cond_qv_reg <= cond_vld_reg[rd_addr];
                sum_qv_reg  <= sum_vld_reg[rd_addr];
            end
        end
    end

    assign filt_rdata = filt_qv_reg ? filt_q_reg : '0;
    assign cond_rdata = cond_qv_reg ? cond_q_reg : '0;
    assign sum_rdata  = sum_qv_reg  ? sum_q_reg  : '0;

endmodule

>>> hdl/fstc_core.sv
// Sequencer for the filter, conductance, tare and force steps; owns the
// channel stores and the shared divider. Uses fstc_pkg, fstc_store, fstc_div.
module fstc_core
    import fstc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [16:0] filter_alpha,
    input  logic [9:0]  tare_frames,
    input  logic [11:0] saturation_level,
    input  logic [19:0] load_resistor_ohm,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [2:0]  channel,
    input  logic [11:0] raw_sample,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_channel,
    output logic [19:0] filtered_level,
    output logic [14:0] force_mn,
    output logic        channel_saturated,
    output logic        frame_saturated,
    output logic        is_tared,
    output logic        tare_accepted,
    output logic [31:0] frame_number
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_FILT  = 4'd2;
    localparam logic [3:0] S_COND  = 4'd3;
    localparam logic [3:0] S_GDIV  = 4'd4;
    localparam logic [3:0] S_GDONE = 4'd5;
    localparam logic [3:0] S_SEG   = 4'd6;
    localparam logic [3:0] S_FDIV  = 4'd7;
    localparam logic [3:0] S_CLOSE = 4'd8;
    localparam logic [3:0] S_ARD   = 4'd9;
    localparam logic [3:0] S_ADIV  = 4'd10;
    localparam logic [3:0] S_TLD   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Control state
    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    logic [AW-1:0] idx_reg;
    logic          ready_reg;
    logic          tared_reg;
    logic [9:0]    sfc_reg;
    logic [31:0]   fcnt_reg;
    logic          acc_reg;
    logic          accepted_reg;
    logic          out_valid_reg;

    // Item payload and datapath
    logic          op_reg;
    logic [2:0]    ch_reg;
    logic          ch_ok_reg;
    logic [11:0]   raw_reg;
    logic          last_reg;
    logic [19:0]   f_old_reg;
    logic          ge_reg;
    logic [36:0]   prod_reg;
    logic [27:0]   tcond_reg;
    logic [37:0]   tsum_reg;
    logic [19:0]   f_reg;
    logic [27:0]   g_reg;
    logic [27:0]   e_reg;
    logic [14:0]   flo_reg;
    logic [14:0]   force_reg;
    logic          csat_reg;

    logic [2:0]    och_out_reg;
    logic [19:0]   level_out_reg;
    logic [14:0]   force_out_reg;
    logic          csat_out_reg;
    logic          fsat_out_reg;
    logic          tared_out_reg;
    logic          acc_out_reg;
    logic [31:0]   fcnt_out_reg;

    // Combinational helpers
    logic          in_fire;
    logic          out_load;
    logic          ch_in_ok;
    logic          tare_on;
    logic          idx_last;
    logic          auto_go;
    logic [16:0]   alpha_eff;
    logic [19:0]   s_val;
    logic          ge_c;
    logic [19:0]   diff_c;
    logic [36:0]   dn_sum;
    logic [19:0]   f_new;
    logic          f_zero;
    logic          f_cap;
    logic [27:0]   q_cap;
    logic          seg_found;
    logic [2:0]    seg;
    logic [17:0]   seg_lo;
    logic [17:0]   seg_off;
    logic [9:0]    seg_dk;
    logic [16:0]   seg_span;
    logic [14:0]   seg_df;
    logic          csat_c;

    // Store and divider hookup
    store_ctl_t    sctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [19:0]   filt_rdata;
    logic [27:0]   cond_rdata;
    logic [37:0]   sum_rdata;
    logic [27:0]   cond_wdata;
    logic [37:0]   sum_wdata;
    logic          div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic          div_done;
    logic [NUM_W-1:0] div_quot;

    fstc_store #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .filt_wdata (f_new),
        .cond_wdata (cond_wdata),
        .sum_wdata  (sum_wdata),
        .filt_rdata (filt_rdata),
        .cond_rdata (cond_rdata),
        .sum_rdata  (sum_rdata)
    );

    fstc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Handshake and shared conditions
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        in_fire   = in_valid && in_ready;
        out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
        ch_in_ok  = 5'(channel) < 5'(CHANNELS);
        tare_on   = !tared_reg && (sfc_reg < tare_frames);
        idx_last  = (idx_reg == AW'(CHANNELS - 1));
        auto_go   = last_reg && tare_on && ((sfc_reg + 10'd1) >= tare_frames);
        alpha_eff = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
        s_val     = {raw_reg, 8'd0};
        ge_c      = s_val >= filt_rdata;
        diff_c    = ge_c ? (s_val - filt_rdata) : (filt_rdata - s_val);
        csat_c    = ch_ok_reg && (f_reg >= {saturation_level, 8'd0});
    end

    // Filter update: step rounded toward minus infinity
    always_comb
    begin
        dn_sum = prod_reg + 37'd65535;
        if (!ready_reg)
        begin
            f_new = s_val;
        end
        else if (ge_reg)
        begin
            f_new = f_old_reg + prod_reg[35:16];
        end
        else
        begin
            f_new = f_old_reg - dn_sum[35:16];
        end
    end

    // Conductance special cases and quotient cap
    always_comb
    begin
        f_zero = (f_reg == '0);
        f_cap  = (f_reg >= LEVEL_FULL) || (load_resistor_ohm == '0);
        q_cap  = (div_quot > NUM_W'(COND_CAP)) ? COND_CAP : div_quot[27:0];
    end

    // Segment search over the knot table; the lowest matching segment wins
    always_comb
    begin
        seg_found = 1'b0;
        seg       = 3'd1;
        for (int i = 7; i >= 1; i--)
        begin
            if (e_reg <= {10'd0, cond_knot(3'(i)), 8'd0})
            begin
                seg_found = 1'b1;
                seg       = 3'(i);
            end
        end
        seg_lo   = {cond_knot(seg - 3'd1), 8'd0};
        seg_off  = e_reg[17:0] - seg_lo;
        seg_dk   = cond_knot(seg) - cond_knot(seg - 3'd1);
        seg_span = {seg_dk[8:0], 8'd0};
        seg_df   = force_knot(seg) - force_knot(seg - 3'd1);
    end

    // Divider operand selection
    always_comb
    begin
        div_start = 1'b0;
        div_num   = NUM_W'(f_reg) * NUM_W'(COND_CAP);
        div_den   = DEN_W'(load_resistor_ohm) * DEN_W'(LEVEL_FULL - f_reg);
        case (state_reg)
            S_COND:
            begin
                div_start = !f_zero && !f_cap;
            end
            S_SEG:
            begin
                div_start = (e_reg != '0) && seg_found;
                div_num   = NUM_W'(seg_off) * NUM_W'(seg_df);
                div_den   = DEN_W'(seg_span);
            end
            S_ARD:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(sum_rdata);
                div_den   = DEN_W'(tare_frames);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Store strobes and addresses
    always_comb
    begin
        sctl       = '0;
        rd_addr    = '0;
        wr_addr    = idx_reg;
        cond_wdata = div_quot[27:0];
        sum_wdata  = tsum_reg + 38'(g_reg);
        case (state_reg)
            S_IDLE:
            begin
                sctl.rd = in_fire;
                rd_addr = (opcode == OP_TARE) ? '0 : AW'(channel);
            end
            S_FILT:
            begin
                sctl.wr_filt = 1'b1;
                wr_addr      = AW'(ch_reg);
            end
            S_GDONE:
            begin
                if (op_reg == OP_SAMPLE)
                begin
                    sctl.wr_sum = tare_on;
                    wr_addr     = AW'(ch_reg);
                end
                else
                begin
                    sctl.wr_cond = 1'b1;
                    cond_wdata   = g_reg;
                    sctl.rd      = !idx_last;
                    rd_addr      = idx_reg + 1'b1;
                end
            end
            S_CLOSE:
            begin
                sctl.rd = auto_go;
            end
            S_ADIV:
            begin
                sctl.wr_cond = div_done;
                sctl.rd      = div_done && !idx_last;
                rd_addr      = idx_reg + 1'b1;
            end
            default:
            begin
                sctl.rd = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OP_TARE)
                    begin
                        state_next = ready_reg ? S_TLD : S_OUT;
                    end
                    else
                    begin
                        state_next = ch_in_ok ? S_RD : S_CLOSE;
                    end
                end
            end
            S_RD:    state_next = S_FILT;
            S_FILT:  state_next = S_COND;
            S_COND:  state_next = (f_zero || f_cap) ? S_GDONE : S_GDIV;
            S_GDIV:  state_next = div_done ? S_GDONE : S_GDIV;
            S_GDONE:
            begin
                if (op_reg == OP_SAMPLE)
                begin
                    state_next = S_SEG;
                end
                else
                begin
                    state_next = idx_last ? S_OUT : S_TLD;
                end
            end
            S_SEG:   state_next = ((e_reg != '0) && seg_found) ? S_FDIV : S_CLOSE;
            S_FDIV:  state_next = div_done ? S_CLOSE : S_FDIV;
            S_CLOSE: state_next = auto_go ? S_ARD : S_OUT;
            S_ARD:   state_next = S_ADIV;
            S_ADIV:
            begin
                if (div_done)
                begin
                    state_next = idx_last ? S_OUT : S_ARD;
                end
            end
            S_TLD:   state_next = S_COND;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            ready_reg     <= 1'b0;
            tared_reg     <= 1'b0;
            sfc_reg       <= '0;
            fcnt_reg      <= '0;
            acc_reg       <= 1'b0;
            accepted_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        idx_reg      <= '0;
                        accepted_reg <= (opcode == OP_TARE) && ready_reg;
                    end
                end
                S_GDONE:
                begin
                    if (op_reg == OP_TARE)
                    begin
                        if (idx_last)
                        begin
                            tared_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_CLOSE:
                begin
                    acc_reg <= acc_reg | csat_c;
                    idx_reg <= '0;
                    if (last_reg)
                    begin
                        ready_reg <= 1'b1;
                        fcnt_reg  <= fcnt_reg + 32'd1;
                        if (tare_on)
                        begin
                            sfc_reg <= sfc_reg + 10'd1;
                        end
                    end
                end
                S_ADIV:
                begin
                    if (div_done)
                    begin
                        if (idx_last)
                        begin
                            tared_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        if ((op_reg == OP_SAMPLE) && last_reg)
                        begin
                            acc_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg    <= opcode;
                    ch_reg    <= channel;
                    ch_ok_reg <= ch_in_ok;
                    raw_reg   <= raw_sample;
                    last_reg  <= frame_last;
                    force_reg <= '0;
                    csat_reg  <= 1'b0;
                end
            end
            S_RD:
            begin
                f_old_reg <= filt_rdata;
                ge_reg    <= ge_c;
                prod_reg  <= 37'(alpha_eff) * 37'(diff_c);
                tcond_reg <= cond_rdata;
                tsum_reg  <= sum_rdata;
            end
            S_FILT:
            begin
                f_reg <= f_new;
            end
            S_COND:
            begin
                g_reg <= f_zero ? '0 : COND_CAP;
            end
            S_GDIV:
            begin
                if (div_done)
                begin
                    g_reg <= q_cap;
                end
            end
            S_GDONE:
            begin
                e_reg <= (g_reg > tcond_reg) ? (g_reg - tcond_reg) : '0;
            end
            S_SEG:
            begin
                flo_reg <= force_knot(seg - 3'd1);
                if (e_reg == '0)
                begin
                    force_reg <= '0;
                end
                else if (!seg_found)
                begin
                    force_reg <= FORCE_MAX;
                end
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    force_reg <= flo_reg + div_quot[14:0];
                end
            end
            S_CLOSE:
            begin
                csat_reg <= csat_c;
            end
            S_TLD:
            begin
                f_reg <= filt_rdata;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    och_out_reg   <= (op_reg == OP_SAMPLE) ? ch_reg : 3'd0;
                    level_out_reg <= ((op_reg == OP_SAMPLE) && ch_ok_reg) ? f_reg : '0;
                    force_out_reg <= force_reg;
                    csat_out_reg  <= csat_reg;
                    fsat_out_reg  <= acc_reg;
                    tared_out_reg <= tared_reg;
                    acc_out_reg   <= accepted_reg;
                    fcnt_out_reg  <= fcnt_reg;
                end
            end
            default:
            begin
                f_reg <= f_reg;
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign out_channel       = och_out_reg;
    assign filtered_level    = level_out_reg;
    assign force_mn          = force_out_reg;
    assign channel_saturated = csat_out_reg;
    assign frame_saturated   = fsat_out_reg;
    assign is_tared          = tared_out_reg;
    assign tare_accepted     = acc_out_reg;
    assign frame_number      = fcnt_out_reg;

endmodule

>>> hdl/force_sensor_filter_tare_convert.sv
// Top level of the force sensor filter, tare and conversion block: register
// port and stream wrapper around fstc_core. Uses fstc_pkg.
//
// One transaction in gives one transaction out, one item at a time. A sample
// uses up to two passes of the shared 48-step divider (level to conductance,
// then table interpolation) besides memory reads, filter update and
// bookkeeping. A frame close that completes the automatic tare adds an
// averaging divide per channel, and an accepted tare command runs the
// conductance step per channel. The next item is taken once the current
// result sits in the output register.
module force_sensor_filter_tare_convert
    import fstc_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // channel[2:0], raw_sample[14:3], zero fill
    input  logic        s_tuser,  // opcode
    input  logic        s_tlast,  // frame_last
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_channel[2:0], filtered_level[22:3], force_mn[37:23],
    // channel_saturated[38], frame_saturated[39], is_tared[40],
    // tare_accepted[41], frame_number[73:42], zero fill
    output logic [79:0] m_tdata
);

    logic [16:0] alpha_reg;
    logic [9:0]  tframes_reg;
    logic [11:0] sat_reg;
    logic [19:0] rload_reg;
    logic        wr_en;

    logic [2:0]  out_channel;
    logic [19:0] filtered_level;
    logic [14:0] force_mn;
    logic        channel_saturated;
    logic        frame_saturated;
    logic        is_tared;
    logic        tare_accepted;
    logic [31:0] frame_number;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 17'd13107;
            tframes_reg <= 10'd250;
            sat_reg     <= 12'd4080;
            rload_reg   <= 20'd47000;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_ALPHA:   alpha_reg   <= pwdata[16:0];
                REG_TFRAMES: tframes_reg <= pwdata[9:0];
                REG_SAT:     sat_reg     <= pwdata[11:0];
                REG_RLOAD:   rload_reg   <= pwdata[19:0];
                default:     alpha_reg   <= alpha_reg;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (paddr[3:2])
            REG_ALPHA:   prdata = {15'd0, alpha_reg};
            REG_TFRAMES: prdata = {22'd0, tframes_reg};
            REG_SAT:     prdata = {20'd0, sat_reg};
            REG_RLOAD:   prdata = {12'd0, rload_reg};
            default:     prdata = '0;
        endcase
    end

    fstc_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .filter_alpha      (alpha_reg),
        .tare_frames       (tframes_reg),
        .saturation_level  (sat_reg),
        .load_resistor_ohm (rload_reg),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .opcode            (s_tuser),
        .channel           (s_tdata[2:0]),
        .raw_sample        (s_tdata[14:3]),
        .frame_last        (s_tlast),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_channel       (out_channel),
        .filtered_level    (filtered_level),
        .force_mn          (force_mn),
        .channel_saturated (channel_saturated),
        .frame_saturated   (frame_saturated),
        .is_tared          (is_tared),
        .tare_accepted     (tare_accepted),
        .frame_number      (frame_number)
    );

    // Pack the result fields
    assign m_tdata = {6'd0, frame_number, tare_accepted, is_tared, frame_saturated,
                      channel_saturated, force_mn, filtered_level, out_channel};

endmodule

>>> hdl/fstc_checker.sv
// Port-level checks for force_sensor_filter_tare_convert, bound to the top
// level below. No package dependency.
module fstc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Take one item at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    // Keep force within the table range
    a_force_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[37:23] <= 15'd20000)
        else $error("force above table range");

    // Fold channel saturation into frame saturation
    a_sat_fold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[38] |-> m_tdata[39])
        else $error("frame saturation misses channel saturation");

    // Report a taken tare with empty sample fields and the tared flag set
    a_tare_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[41] |-> m_tdata[2:0] == 3'd0 && m_tdata[38:3] == '0
            && m_tdata[40])
        else $error("tare result carries sample fields");

endmodule

bind force_sensor_filter_tare_convert fstc_checker u_fstc_checker (.*);

>>> bench/tb_force_sensor_filter_tare_convert.sv
// Testbench for force_sensor_filter_tare_convert: drives samples and tare
// commands, predicts each result in a scoreboard class and checks it.
// Depends on fstc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_force_sensor_filter_tare_convert;
    import fstc_pkg::*;

    localparam int NCH        = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_OFF   = 800;

    // One result transaction, laid out as on m_tdata (MSB first)
    typedef struct packed {
        logic [5:0]  pad;
        logic [31:0] frame_number;
        logic        tare_accepted;
        logic        is_tared;
        logic        frame_saturated;
        logic        channel_saturated;
        logic [14:0] force_mn;
        logic [19:0] filtered_level;
        logic [2:0]  out_channel;
    } result_t;

    class force_scoreboard;
        logic [16:0] alpha;
        logic [9:0]  tare_frames;
        logic [11:0] sat_level;
        logic [19:0] load_ohm;
        logic [19:0] level_mem [NCH];
        logic [27:0] tare_cond [NCH];
        logic [37:0] tare_sum  [NCH];
        bit          ready;
        bit          tared;
        bit          sat_acc;
        logic [9:0]  startup_cnt;
        logic [31:0] frames;
        result_t     pending [$];
        int          mismatches;
        int          checked;
        int          tares_taken;
        int          saturated_seen;

        function new();
            alpha       = 17'd13107;
            tare_frames = 10'd250;
            sat_level   = 12'd4080;
            load_ohm    = 20'd47000;
            for (int i = 0; i < NCH; i++)
            begin
                level_mem[i] = '0;
                tare_cond[i] = '0;
                tare_sum[i]  = '0;
            end
            ready       = 0;
            tared       = 0;
            sat_acc     = 0;
            startup_cnt = '0;
            frames      = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_ALPHA:   alpha       = v[16:0];
                REG_TFRAMES: tare_frames = v[9:0];
                REG_SAT:     sat_level   = v[11:0];
                REG_RLOAD:   load_ohm    = v[19:0];
                default:     ;
            endcase
        endfunction

        // Divider formula: level in Q12.8 to conductance in Q20.8 uS
        function logic [27:0] cond_of(logic [19:0] f);
            longint unsigned num;
            longint unsigned den;
            longint unsigned g;
            if (f == 0) return '0;
            if (f >= LEVEL_FULL || load_ohm == 0) return COND_CAP;
            num = 64'd256000000 * f;
            den = longint'(load_ohm) * (64'd1048320 - f);
            g = num / den;
            if (g > 64'd256000000) g = 64'd256000000;
            return g[27:0];
        endfunction

        // Piecewise linear map from conductance to millinewtons
        function logic [14:0] force_of(logic [27:0] e);
            int unsigned     gk [8];
            int unsigned     fk [8];
            longint unsigned d;
            gk = '{0, 9, 19, 32, 54, 141, 284, 554};
            fk = '{0, 200, 500, 1000, 2000, 5000, 10000, 20000};
            if (e == 0) return '0;
            for (int i = 1; i < 8; i++)
            begin
                if (e <= gk[i] * 256)
                begin
                    d = longint'(e - gk[i-1] * 256) * (fk[i] - fk[i-1]);
                    return 15'(fk[i-1] + d / ((gk[i] - gk[i-1]) * 256));
                end
            end
            return FORCE_MAX;
        endfunction

        function void note_input(bit op, logic [2:0] ch, logic [11:0] raw, bit last);
            result_t         r;
            logic [31:0]     f;
            logic [31:0]     s;
            longint unsigned a;
            longint unsigned p;
            logic [27:0]     g;
            logic [27:0]     ex;
            r = '0;
            if (op == OP_TARE)
            begin
                if (ready)
                begin
                    for (int i = 0; i < NCH; i++)
                        tare_cond[i] = cond_of(level_mem[i]);
                    tared = 1;
                    r.tare_accepted = 1;
                    tares_taken++;
                end
            end
            else
            begin
                r.out_channel = ch;
                f = level_mem[ch];
                s = {20'd0, raw} << 8;
                a = (alpha > ALPHA_ONE) ? 65536 : alpha;
                // Step toward the sample, rounding toward minus infinity
                if (!ready)
                    f = s;
                else if (s >= f)
                    f = f + 32'((a * (s - f)) >> 16);
                else
                begin
                    p = a * (f - s);
                    f = f - 32'((p + 65535) >> 16);
                end
                f = f & 32'hFFFFF;
                level_mem[ch] = f[19:0];
                g = cond_of(f[19:0]);
                if (!tared && startup_cnt < tare_frames)
                    tare_sum[ch] = tare_sum[ch] + g;
                ex = (g > tare_cond[ch]) ? g - tare_cond[ch] : '0;
                r.force_mn = force_of(ex);
                r.filtered_level = f[19:0];
                r.channel_saturated = (f >= ({20'd0, sat_level} << 8));
                if (r.channel_saturated)
                begin
                    sat_acc = 1;
                    saturated_seen++;
                end
                // Close the frame, finishing the startup tare when it is due
                if (last)
                begin
                    if (!tared && startup_cnt < tare_frames)
                    begin
                        startup_cnt = startup_cnt + 1;
                        if (startup_cnt >= tare_frames)
                        begin
                            for (int i = 0; i < NCH; i++)
                                tare_cond[i] = 28'(tare_sum[i] / tare_frames);
                            tared = 1;
                        end
                    end
                    ready = 1;
                    frames = frames + 1;
                end
            end
            r.frame_saturated = sat_acc;
            r.is_tared = tared;
            r.frame_number = frames;
            if (op == OP_SAMPLE && last) sat_acc = 0;
            pending.push_back(r);
        endfunction

        function void check_result(logic [79:0] data);
            result_t got;
            result_t exp_r;
            string   bad;
            got = result_t'(data);
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with none expected: %h", data);
                return;
            end
            exp_r = pending.pop_front();
            bad = "";
            if (got.out_channel != exp_r.out_channel) bad = {bad, " out_channel"};
            if (got.filtered_level != exp_r.filtered_level) bad = {bad, " filtered_level"};
            if (got.force_mn != exp_r.force_mn) bad = {bad, " force_mn"};
            if (got.channel_saturated != exp_r.channel_saturated)
                bad = {bad, " channel_saturated"};
            if (got.frame_saturated != exp_r.frame_saturated) bad = {bad, " frame_saturated"};
            if (got.is_tared != exp_r.is_tared) bad = {bad, " is_tared"};
            if (got.tare_accepted != exp_r.tare_accepted) bad = {bad, " tare_accepted"};
            if (got.frame_number != exp_r.frame_number) bad = {bad, " frame_number"};
            if (bad != "")
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d differs in%s", checked, bad);
                    $display("  exp ch=%0d lvl=%0d f=%0d cs=%b fs=%b t=%b a=%b fr=%0d",
                             exp_r.out_channel, exp_r.filtered_level, exp_r.force_mn,
                             exp_r.channel_saturated, exp_r.frame_saturated,
                             exp_r.is_tared, exp_r.tare_accepted, exp_r.frame_number);
                    $display("  got ch=%0d lvl=%0d f=%0d cs=%b fs=%b t=%b a=%b fr=%0d",
                             got.out_channel, got.filtered_level, got.force_mn,
                             got.channel_saturated, got.frame_saturated,
                             got.is_tared, got.tare_accepted, got.frame_number);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // channel[2:0], raw_sample[14:3], zero fill
    logic        s_tuser;   // opcode
    logic        s_tlast;   // frame_last
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // out_channel .. frame_number, see result_t

    force_scoreboard sb;
    int  items_sent;
    int  burst_left;
    int  gap_max;
    bit  valid_high;
    int  idle_cycles;

    force_sensor_filter_tare_convert #(.CHANNELS(NCH)) dut (.*);

    // Clock
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: stall on shifting patterns, hold off once for a long stretch
    initial
    begin
        int  mode;
        bit  held;
        held = 0;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            for (int i = 0; i < 50; i++)
            begin
                @(posedge clk);
                if (!held && sb.checked >= 120)
                begin
                    held = 1;
                    m_tready <= 0;
                    repeat (HOLD_OFF) @(posedge clk);
                end
                case (mode)
                    0:       m_tready <= 1;
                    1:       m_tready <= $urandom_range(0, 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        sb.write_reg(idx, v);
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(logic [16:0] a, logic [9:0] tf, logic [11:0] sat,
                             logic [19:0] r);
        drain();
        write_reg(REG_ALPHA, a);
        write_reg(REG_TFRAMES, tf);
        write_reg(REG_SAT, sat);
        write_reg(REG_RLOAD, r);
    endtask

    // Offer one transaction; drop valid between bursts
    task automatic push_item(bit op, logic [2:0] ch, logic [11:0] raw, bit last);
        s_tvalid   <= 1;
        s_tuser    <= op;
        s_tdata    <= {1'b0, raw, ch};
        s_tlast    <= last;
        valid_high = 1;
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, ch, raw, last);
        items_sent++;
        if (burst_left == 0)
        begin
            s_tvalid   <= 0;
            valid_high = 0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(0, 10);
        end
        else
            burst_left--;
    endtask

    task automatic end_phase();
        if (valid_high)
        begin
            s_tvalid   <= 0;
            valid_high = 0;
            @(posedge clk);
        end
    endtask

    function automatic logic [11:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd4095;
            2, 3:    return 12'($urandom_range(3500, 4095));
            default: return 12'($urandom);
        endcase
    endfunction

    // Mostly whole frames in channel order, with broken frames and tares mixed in
    task automatic random_items(int n);
        int start;
        start = items_sent;
        gap_max = $urandom_range(0, 1) ? 1 : 8;
        while (items_sent - start < n)
        begin
            case ($urandom_range(0, 9))
                0:
                    push_item(OP_TARE, 3'($urandom), 12'($urandom), $urandom_range(0, 1));
                1, 2:
                    for (int i = 0; i < 3; i++)
                        push_item(OP_SAMPLE, 3'($urandom), pick_raw(),
                                  $urandom_range(0, 3) == 0);
                default:
                    for (int c = 0; c < NCH; c++)
                        push_item(OP_SAMPLE, 3'(c), pick_raw(), c == NCH - 1);
            endcase
        end
        end_phase();
    endtask

    initial
    begin
        sb = new();
        items_sent  = 0;
        burst_left  = 0;
        gap_max     = 4;
        valid_high  = 0;
        idle_cycles = 0;
        rst_n    = 0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 0;
        s_tuser  = 0;
        s_tdata  = '0;
        s_tlast  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: early tare refused, two startup frames, then a tare accepted
        write_reg(REG_TFRAMES, 10'd2);
        push_item(OP_TARE, 3'd5, 12'd100, 1'b1);
        for (int c = 0; c < NCH; c++)
            push_item(OP_SAMPLE, 3'(c), (c % 2) ? 12'd4095 : 12'd0, c == NCH - 1);
        for (int c = 0; c < NCH; c++)
            push_item(OP_SAMPLE, 3'(c), 12'(c * 585), c == NCH - 1);
        push_item(OP_TARE, 3'd7, 12'd4095, 1'b0);
        push_item(OP_SAMPLE, 3'd2, 12'd4095, 1'b0);
        push_item(OP_SAMPLE, 3'd1, 12'd0, 1'b0);
        push_item(OP_SAMPLE, 3'd6, 12'd3000, 1'b1);
        end_phase();

        // Settings sweep, extremes first
        configure(17'd65536, 10'd1, 12'd4095, 20'd1);
        random_items(70);
        configure(17'd131071, 10'd1023, 12'd0, 20'd1048575);
        random_items(70);
        configure(17'd0, 10'd0, 12'd2000, 20'd0);
        random_items(60);
        configure(17'd20000, 10'd3, 12'd3500, 20'd4700);
        random_items(80);
        configure(17'd13107, 10'd250, 12'd4080, 20'd47000);
        random_items(70);
        configure(17'($urandom_range(0, 131071)), 10'($urandom), 12'($urandom),
                  20'($urandom));
        random_items(80);

        drain();
        repeat (200) @(posedge clk);
        $display("Run covered %0d items, %0d results, %0d tares taken, %0d saturated",
                 items_sent, sb.checked, sb.tares_taken, sb.saturated_seen);
        $display("across six register settings; %0d mismatches, %0d left over",
                 sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
